// ===== src/psd_pkg.sv =====
// Shared types, constants and codes for the per-shard delay running mean block.
package psd_pkg;

   localparam int unsigned SHARDS_DEFAULT = 16;
   localparam int unsigned MASK_BITS      = 16;
   localparam int unsigned DIV_STEPS      = 64;
   localparam logic [31:0] LIMIT_RESET    = 32'd400000;
   localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [3:0]  shard;
      logic [31:0] delay;
      logic [15:0] shard_mask;
   } psd_req_type;

   typedef struct packed {
      logic [31:0] bound;
      logic        sample_dropped;
   } psd_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [32:0] divisor;
   } psd_div_req_type;

   typedef struct packed {
      logic        en;
      logic [31:0] mean;
      logic [31:0] count;
   } psd_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_QRD,
      ST_QCMP
   } psd_state_type;

endpackage

// ===== src/psd_table.sv =====
// Per-shard mean and count store with valid bits and registered read.
module psd_table #(
   parameter int unsigned SHARDS = psd_pkg::SHARDS_DEFAULT,
   parameter int unsigned IDX_W  = (SHARDS > 1) ? $clog2(SHARDS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_W-1:0]    rd_addr,
   output logic [31:0]         rd_mean,
   output logic [31:0]         rd_count,
   input  logic [IDX_W-1:0]    wr_addr,
   input  psd_pkg::psd_wr_type wr
);
   import psd_pkg::*;

   logic [63:0]       mem [SHARDS];
   logic [SHARDS-1:0] valid_ff;
   logic [63:0]       rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= {wr.mean, wr.count};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // never-written entries read as zero
   assign rd_mean  = rd_valid_ff ? rd_data_ff[63:32] : '0;
   assign rd_count = rd_valid_ff ? rd_data_ff[31:0]  : '0;

endmodule

// ===== src/psd_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 33-bit divisor.
module psd_div (
   input  logic                     clock,
   input  logic                     reset,
   input  psd_pkg::psd_div_req_type req,
   output logic                     done,
   output logic [31:0]              quotient
);
   import psd_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_STEPS);

   logic [31:0]      rem_ff, rem_in;
   logic [63:0]      quo_ff, quo_in;
   logic [32:0]      divisor_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             running_ff, running_in;
   logic             done_ff, done_in;
   logic [32:0]      shifted;
   logic [32:0]      diff;
   logic             take;

   always_comb begin
      shifted    = {rem_ff, quo_ff[63]};
      diff       = shifted - divisor_ff;
      take       = (shifted >= divisor_ff);
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (req.start) begin
         rem_in     = '0;
         quo_in     = req.dividend;
         cnt_in     = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         // remainder stays below the divisor, so 32 bits hold it
         rem_in = take ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[62:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (req.start) begin
         divisor_ff <= req.divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[31:0];

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(running_ff) && !running_ff)
      else $error("divider done without a finished run");

endmodule

// ===== src/per_shard_delay_running_mean.sv =====
// Top level: per-shard running mean of delay with anomaly filter and max-mean query.
//
//  channel   ports                          handshake
//  request   start, busy, req_data          taken when start high and busy low
//  response  rsp_strobe, rsp_data           one-cycle strobe, no back-pressure
//  config    csr_wr_en, csr_wr_data         written when csr_wr_en high
//
// A kept sample goes from accept to response through a table read, a 32x32
// multiply, a 64-bit add and then the bit-serial divider.
// A dropped sample answers in the cycle after accept and keeps busy low.
// A query makes one table read and one compare per shard, over the first min(SHARDS,16) shards.
// Reset clears both tables (per-entry valid bits) and sets the limit to 400000.
// Responses cannot be stalled; busy alone throttles the request side.
module per_shard_delay_running_mean #(
   parameter int unsigned SHARDS = psd_pkg::SHARDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  psd_pkg::psd_req_type req_data,
   output logic                 rsp_strobe,
   output psd_pkg::psd_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data
);
   import psd_pkg::*;

   localparam int unsigned IDX_W    = (SHARDS > 1) ? $clog2(SHARDS) : 1;
   localparam int unsigned QRY_N    = (SHARDS < MASK_BITS) ? SHARDS : MASK_BITS;
   localparam logic [IDX_W-1:0] QRY_LAST = IDX_W'(QRY_N - 1);

   psd_state_type    state_ff, state_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   psd_rsp_type      rsp_data_ff, rsp_data_in;
   logic [31:0]      limit_ff;
   psd_req_type      req_ff, req_in;
   logic [63:0]      prod_ff, prod_in;
   logic [31:0]      count_ff, count_in;
   logic [31:0]      best_ff, best_in;
   logic [15:0]      mask_ff, mask_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      rd_mean;
   logic [31:0]      rd_count;
   psd_wr_type       wr;
   psd_div_req_type  div_req;
   logic             div_done;
   logic [31:0]      div_quotient;
   logic             accept;
   logic             drop;

   psd_table #(
      .SHARDS (SHARDS),
      .IDX_W  (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_mean  (rd_mean),
      .rd_count (rd_count),
      .wr_addr  (IDX_W'(req_ff.shard)),
      .wr       (wr)
   );

   psd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign drop   = (32'(req_data.shard) >= SHARDS) || (req_data.delay >= limit_ff);

   always_comb begin
      state_in         = state_ff;
      rsp_strobe_in    = 1'b0;
      rsp_data_in      = rsp_data_ff;
      req_in           = req_ff;
      prod_in          = prod_ff;
      count_in         = count_ff;
      best_in          = best_ff;
      mask_in          = mask_ff;
      idx_in           = idx_ff;
      rd_addr          = idx_ff;
      wr.en            = 1'b0;
      wr.mean          = div_quotient;
      wr.count         = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 32'd1;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff + {32'd0, req_ff.delay};
      div_req.divisor  = {1'b0, count_ff} + 33'd1;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = IDX_W'(req_data.shard);
            if (accept) begin
               req_in = req_data;
               if (req_data.kind == KIND_QUERY) begin
                  best_in  = '0;
                  mask_in  = req_data.shard_mask;
                  idx_in   = '0;
                  state_in = ST_QRD;
               end else if (drop) begin
                  // answer at once, stay idle
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '{bound: '0, sample_dropped: 1'b1};
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = 64'(rd_mean) * 64'(rd_count);
            count_in = rd_count;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               wr.en         = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{bound: '0, sample_dropped: 1'b0};
               state_in      = ST_IDLE;
            end
         end
         ST_QRD: begin
            state_in = ST_QCMP;
         end
         ST_QCMP: begin
            if (mask_ff[0] && (rd_mean > best_ff)) begin
               best_in = rd_mean;
            end
            mask_in = mask_ff >> 1;
            if (idx_ff == QRY_LAST) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{bound: best_in, sample_dropped: 1'b0};
               state_in      = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_QRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         limit_ff      <= LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      req_ff      <= req_in;
      prod_ff     <= prod_in;
      count_ff    <= count_in;
      best_ff     <= best_in;
      mask_ff     <= mask_in;
      idx_ff      <= idx_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy)
      else $error("response beat while still busy");

   a_drop_zero_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_data_ff.sample_dropped |-> rsp_data_ff.bound == '0)
      else $error("dropped sample carries a bound");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_QUERY |=> busy && !rsp_strobe_ff)
      else $error("query not taken into the sweep");

endmodule

// ===== tb/psd_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts per-shard mean delay responses and compares each response beat.
module psd_checker #(
   parameter int unsigned SHARDS = psd_pkg::SHARDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  psd_pkg::psd_req_type req_data,
   input  logic                 rsp_strobe,
   input  psd_pkg::psd_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   output int                   errors,
   output int                   outstanding
);
   import psd_pkg::*;

   logic [31:0] limit_reg;
   logic [31:0] mean_tbl [SHARDS];
   logic [31:0] count_tbl [SHARDS];
   psd_rsp_type bound_q [$];

   // Apply one request to the shadow tables and return the response it should give.
   function automatic psd_rsp_type track_delay(input psd_req_type item);
      psd_rsp_type res;
      logic [63:0] total;
      logic [63:0] divisor;
      logic [63:0] quot;
      res = '0;
      if (item.kind == KIND_SAMPLE) begin
         if (int'(item.shard) >= SHARDS || item.delay >= limit_reg) begin
            res.sample_dropped = 1'b1;
         end else begin
            total = 64'(mean_tbl[item.shard]) * 64'(count_tbl[item.shard])
                    + 64'(item.delay);
            // divisor is count + 1 in full width, so a saturated count still divides
            divisor = 64'(count_tbl[item.shard]) + 64'd1;
            quot = total / divisor;
            mean_tbl[item.shard] = quot[31:0];
            if (count_tbl[item.shard] != COUNT_MAX) begin
               count_tbl[item.shard] = count_tbl[item.shard] + 32'd1;
            end
         end
      end else begin
         for (int i = 0; i < SHARDS && i < MASK_BITS; i++) begin
            if (item.shard_mask[i] && mean_tbl[i] > res.bound) begin
               res.bound = mean_tbl[i];
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      psd_rsp_type want;
      if (reset) begin
         limit_reg = LIMIT_RESET;
         for (int i = 0; i < SHARDS; i++) begin
            mean_tbl[i] = '0;
            count_tbl[i] = '0;
         end
         bound_q.delete();
      end else begin
         if (csr_wr_en) begin
            limit_reg = csr_wr_data;
         end
         if (rsp_strobe) begin
            if (bound_q.size() == 0) begin
               $error("response beat with no request waiting: bound %0d sample_dropped %0b",
                      rsp_data.bound, rsp_data.sample_dropped);
               errors++;
            end else begin
               want = bound_q.pop_front();
               if (rsp_data.bound !== want.bound) begin
                  $error("bound: expected %0d, got %0d", want.bound, rsp_data.bound);
                  errors++;
               end
               if (rsp_data.sample_dropped !== want.sample_dropped) begin
                  $error("sample_dropped: expected %0b, got %0b",
                         want.sample_dropped, rsp_data.sample_dropped);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            bound_q.insert(bound_q.size(), track_delay(req_data));
         end
      end
      outstanding = bound_q.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives samples, queries and limit writes into the running mean block.
module tb;
   import psd_pkg::*;

   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 175;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   psd_req_type req_data = '0;
   logic        rsp_strobe;
   psd_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   int          errors;
   int          outstanding;
   int          max_gap = 3;
   logic [31:0] limit_now = LIMIT_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   per_shard_delay_running_mean DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   psd_checker CHK (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .outstanding (outstanding)
   );

   function automatic psd_req_type sample_item(input logic [3:0] shard,
                                               input logic [31:0] delay);
      psd_req_type item;
      item = '0;
      item.kind = KIND_SAMPLE;
      item.shard = shard;
      item.delay = delay;
      return item;
   endfunction

   function automatic psd_req_type query_item(input logic [15:0] mask);
      psd_req_type item;
      item = '0;
      item.kind = KIND_QUERY;
      item.shard_mask = mask;
      return item;
   endfunction

   function automatic psd_req_type random_item();
      psd_req_type item;
      int pick;
      // randomize every field, including the ones this kind ignores
      item.shard = 4'($urandom_range(0, 15));
      item.delay = $urandom;
      item.shard_mask = 16'($urandom);
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 9) < 6) begin
         item.kind = KIND_SAMPLE;
         case (pick)
            7: item.delay = limit_now;
            8: item.delay = limit_now - 32'd1;
            9: ;
            default: item.delay = $urandom_range(0, limit_now - 32'd1);
         endcase
      end else begin
         item.kind = KIND_QUERY;
         case (pick)
            0: item.shard_mask = '0;
            1: item.shard_mask = '1;
            2, 3: item.shard_mask = 16'(1) << $urandom_range(0, 15);
            default: ;
         endcase
      end
      return item;
   endfunction

   // Hold start high until the beat is taken.
   task automatic issue_request(input psd_req_type item);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_now = value;
   endtask

   initial begin
      logic [31:0] phase_limit [PHASES];
      phase_limit[0] = LIMIT_RESET;
      phase_limit[1] = 32'hFFFF_FFFF;
      phase_limit[2] = 32'd1;
      phase_limit[3] = 32'd1000;
      phase_limit[4] = $urandom_range(1, 32'hFFFF_FFFF);
      phase_limit[5] = 32'h8000_0000;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // untouched shards and empty selection read as zero; then samples at the limit edge and single-shard queries
      issue_request(query_item(16'hFFFF));
      issue_request(query_item(16'h0000));
      issue_request(sample_item(4'd0, 32'd0));
      issue_request(sample_item(4'd15, LIMIT_RESET - 32'd1));
      issue_request(sample_item(4'd15, LIMIT_RESET));
      issue_request(sample_item(4'd7, 32'hFFFF_FFFF));
      issue_request(sample_item(4'd15, 32'd1));
      issue_request(query_item(16'h8000));
      issue_request(query_item(16'h0001));
      issue_request(query_item(16'hFFFF));

      // full-range limit: products of large means and counts need 64 bits
      drain_pipeline();
      write_limit(32'hFFFF_FFFF);
      issue_request(sample_item(4'd3, 32'hFFFF_FFFE));
      issue_request(sample_item(4'd3, 32'hFFFF_FFFE));
      issue_request(sample_item(4'd3, 32'hFFFF_FFFF));
      issue_request(sample_item(4'd3, 32'd0));
      issue_request(sample_item(4'd3, 32'hFFFF_FFFE));
      issue_request(query_item(16'hFFFF));
      issue_request(query_item(16'h7FF7));

      // smallest limit: only a zero delay gets through
      drain_pipeline();
      write_limit(32'd1);
      issue_request(sample_item(4'd5, 32'd0));
      issue_request(sample_item(4'd5, 32'd1));
      issue_request(query_item(16'h0020));
      issue_request(query_item(16'h0008));

      for (int p = 0; p < PHASES; p++) begin
         drain_pipeline();
         write_limit(phase_limit[p]);
         max_gap = (p % 2 == 0) ? 3 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            issue_request(random_item());
            if ($urandom_range(0, 39) == 0) begin
               drain_pipeline();
            end
         end
      end

      drain_pipeline();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== per_shard_delay_running_mean.f =====
src/psd_pkg.sv
src/psd_table.sv
src/psd_div.sv
src/per_shard_delay_running_mean.sv
tb/psd_checker.sv
tb/tb.sv
